// File: sv/text_terminal_character_engine_defines.svh
// Assertion macros shared by the terminal character engine.
// The macros expect signals named clk and rst in the module that uses them.
`ifndef TEXT_TERMINAL_CHARACTER_ENGINE_DEFINES_SVH
`define TEXT_TERMINAL_CHARACTER_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define TTCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttce: same-cycle check failed");
`define TTCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttce: next-cycle check failed");
`else
`define TTCE_ASSERT_IMP(lbl, ante, cons)
`define TTCE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: sv/ttce_pkg.sv
package ttce_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SCROLL = 2'd1,
    OP_REPORT = 2'd2,
    OP_ESCAPE = 2'd3
  } op_kind_t;

  typedef enum logic [3:0] {
    CL_PRINT,
    CL_HIGH,
    CL_ESC,
    CL_NOP,
    CL_BS,
    CL_TAB,
    CL_LF,
    CL_CR,
    CL_CTRL
  } byte_class_t;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_ROWS    = 2'd0;
  localparam logic [1:0] REG_COLS    = 2'd1;
  localparam logic [1:0] REG_WRAP    = 2'd2;
  localparam logic [1:0] REG_NEWLINE = 2'd3;

  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_VT  = 8'h0B;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_SO  = 8'h0E;
  localparam logic [7:0] BYTE_SI  = 8'h0F;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;
  localparam logic [7:0] HIGH_LO  = 8'h7F;
  localparam logic [7:0] HIGH_HI  = 8'hFF;

  localparam logic [7:0] GLYPH_TILDE  = 8'h7E;
  localparam logic [7:0] GLYPH_LPAREN = 8'h28;
  localparam logic [7:0] GLYPH_CARET  = 8'h5E;
  localparam logic [7:0] GLYPH_RPAREN = 8'h29;

  localparam logic [7:0] RESET_ROWS = 8'd30;
  localparam logic [7:0] RESET_COLS = 8'd80;

  // Cells written by a control byte shown in caret form.
  localparam logic [2:0] CTRL_CELLS = 3'd4;

  // One display-memory operation as it leaves the block.
  typedef struct packed {
    op_kind_t    kind;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [7:0]  glyph;
    logic        last;
  } op_t;

  // Progress through the operations of the byte being worked on.
  typedef struct packed {
    logic [2:0] phase;
    logic       scroll_pend;
  } seq_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    case (b) inside
      [PRINT_LO:PRINT_HI]:          c = CL_PRINT;
      [HIGH_LO:HIGH_HI]:            c = CL_HIGH;
      BYTE_ESC:                     c = CL_ESC;
      BYTE_BEL, BYTE_SO, BYTE_SI:   c = CL_NOP;
      BYTE_BS:                      c = CL_BS;
      BYTE_TAB:                     c = CL_TAB;
      BYTE_LF, BYTE_VT, BYTE_FF:    c = CL_LF;
      BYTE_CR:                      c = CL_CR;
      default:                      c = CL_CTRL;
    endcase
    return c;
  endfunction

endpackage

// File: sv/ttce_step.sv
module ttce_step #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 128,
  parameter int TAB_WIDTH = 8,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic [7:0]       byte_in,
  input  ttce_pkg::seq_t   seq,
  input  logic [RW-1:0]    cursor_row,
  input  logic [CW-1:0]    cursor_col,
  input  logic [6:0]       rows_in_use,
  input  logic [7:0]       cols_in_use,
  input  logic             wrap_enable,
  input  logic             newline_mode,
  output ttce_pkg::op_t    op,
  output ttce_pkg::seq_t   seq_next,
  output logic [RW-1:0]    row_next,
  output logic [CW-1:0]    col_next
);
  import ttce_pkg::*;

  localparam int RSW = $clog2(MAX_ROWS + 1);
  localparam int RCW = (RSW > 7) ? RSW : 7;
  localparam int CSW = $clog2(MAX_COLS + TAB_WIDTH + 1);
  localparam int CCW = (CSW > 8) ? CSW : 8;

  // Next tab stop for every column, fixed at elaboration.
  logic [CCW-1:0] tab_stop [MAX_COLS];
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_tab
    assign tab_stop[i] = CCW'((i / TAB_WIDTH + 1) * TAB_WIDTH);
  end

  byte_class_t    cls;
  logic [RCW-1:0] rows_ext, eff_rows, cr, rn;
  logic [CCW-1:0] cols_ext, eff_cols, cc, cn, tab_next;
  logic [2:0]     ncells;
  logic [7:0]     glyph_sel;
  logic           row_ok, col_ok;

  always_comb begin
    cls = classify(byte_in);

    rows_ext = RCW'(rows_in_use);
    if (rows_ext == '0) begin
      eff_rows = RCW'(1);
    end else if (rows_ext > RCW'(MAX_ROWS)) begin
      eff_rows = RCW'(MAX_ROWS);
    end else begin
      eff_rows = rows_ext;
    end
    cols_ext = CCW'(cols_in_use);
    if (cols_ext == '0) begin
      eff_cols = CCW'(1);
    end else if (cols_ext > CCW'(MAX_COLS)) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = cols_ext;
    end

    // A shrunken screen pulls the cursor onto its last row or column.
    cr = (RCW'(cursor_row) >= eff_rows) ? eff_rows - RCW'(1) : RCW'(cursor_row);
    cc = (CCW'(cursor_col) >= eff_cols) ? eff_cols - CCW'(1) : CCW'(cursor_col);
    row_ok = cr < eff_rows - RCW'(1);
    col_ok = cc < eff_cols - CCW'(1);
    tab_next = tab_stop[cc[CW-1:0]];

    case (cls)
      CL_PRINT, CL_HIGH, CL_LF: ncells = 3'd1;
      CL_CTRL:                  ncells = CTRL_CELLS;
      default:                  ncells = 3'd0;
    endcase

    case (cls)
      CL_PRINT: glyph_sel = byte_in;
      CL_HIGH:  glyph_sel = GLYPH_TILDE;
      default: begin
        case (seq.phase)
          3'd0:    glyph_sel = GLYPH_LPAREN;
          3'd1:    glyph_sel = GLYPH_CARET;
          3'd2:    glyph_sel = byte_in;
          default: glyph_sel = GLYPH_RPAREN;
        endcase
      end
    endcase

    op       = '{kind: OP_REPORT, row: cr[5:0], col: cc[6:0], glyph: 8'd0, last: 1'b0};
    seq_next = seq;
    rn       = cr;
    cn       = cc;

    if (seq.scroll_pend) begin
      op.kind              = OP_SCROLL;
      op.row               = '0;
      op.col               = '0;
      seq_next.scroll_pend = 1'b0;
    end else if (cls == CL_ESC) begin
      op.kind = OP_ESCAPE;
      op.last = 1'b1;
    end else if (seq.phase < ncells) begin
      if (cls == CL_LF) begin
        if (newline_mode) begin
          cn = '0;
        end
        if (row_ok) begin
          rn      = cr + RCW'(1);
          op.row  = rn[5:0];
          op.col  = cn[6:0];
          op.last = 1'b1;
        end else begin
          // Bottom row: scroll now, report on the next operation.
          op.kind        = OP_SCROLL;
          op.row         = '0;
          op.col         = '0;
          seq_next.phase = seq.phase + 3'd1;
        end
      end else begin
        op.kind        = OP_WRITE;
        op.glyph       = glyph_sel;
        seq_next.phase = seq.phase + 3'd1;
        if (col_ok) begin
          cn = cc + CCW'(1);
        end else if (wrap_enable) begin
          cn = '0;
          if (row_ok) begin
            rn = cr + RCW'(1);
          end else begin
            seq_next.scroll_pend = 1'b1;
          end
        end
      end
    end else begin
      case (cls)
        CL_BS: begin
          if (cc != '0) begin
            cn = cc - CCW'(1);
          end
        end
        CL_TAB: cn = (tab_next < eff_cols) ? tab_next : eff_cols - CCW'(1);
        CL_CR:  cn = '0;
        default: ;
      endcase
      op.row  = rn[5:0];
      op.col  = cn[6:0];
      op.last = 1'b1;
    end

    if (op.last) begin
      seq_next = '0;
    end

    row_next = rn[RW-1:0];
    col_next = cn[CW-1:0];
  end

endmodule

// File: sv/text_terminal_character_engine.sv
// Text terminal character engine. Bytes arrive one per transfer on the input
// channel; each byte becomes a short list of display-memory operations on the
// output channel, one operation per transfer: cell writes, whole-screen scrolls
// up by one row, and a closing cursor report that carries the cursor position
// after the byte (ESC instead gives one escape-handoff operation). The last
// operation of a byte has last set. The block issues one operation per clock
// while out_ready is high, limited by its single result register, and takes
// the next byte in the same cycle that the final operation of the previous
// byte is issued. A printable byte gives two operations (write and report),
// three when it wraps at the bottom row and scrolls; a control byte shown in
// caret form gives five to nine; cursor moves, ignored bytes and ESC give one,
// a line feed at the bottom row two. The user writes screen size, wrap and
// newline mode through the configuration port while the block is idle, which
// the block does not enforce; sizes of zero act as one and sizes above the maximum act as the maximum.
`include "text_terminal_character_engine_defines.svh"

module text_terminal_character_engine #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 128,
  parameter int TAB_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration writes.
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Byte stream in.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  // Operations out.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] op_kind,
  output logic [5:0] row,
  output logic [6:0] col,
  output logic [7:0] glyph,
  output logic       last
);
  import ttce_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_COLS);

  // Configuration registers.
  logic [6:0] rows_in_use;
  logic [7:0] cols_in_use;
  logic       wrap_enable;
  logic       newline_mode;

  // Cursor state.
  logic [RW-1:0] cursor_row;
  logic [CW-1:0] cursor_col;

  // Input register: the byte whose operations are being issued.
  logic       cur_valid;
  logic [7:0] cur_byte;
  seq_t       seq;

  // Result register.
  op_t out_op;

  op_t           step_op;
  seq_t          seq_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic          advance;
  logic          in_take;

  ttce_step #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_step (
    .byte_in      (cur_byte),
    .seq          (seq),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col),
    .rows_in_use  (rows_in_use),
    .cols_in_use  (cols_in_use),
    .wrap_enable  (wrap_enable),
    .newline_mode (newline_mode),
    .op           (step_op),
    .seq_next     (seq_next),
    .row_next     (row_next),
    .col_next     (col_next)
  );

  // An operation moves into the result register whenever that register is
  // empty or being emptied by a transfer in the same cycle.
  assign advance  = cur_valid && (!out_valid || out_ready);
  // A new byte enters as the final operation of the current one leaves.
  assign in_ready = !cur_valid || (advance && step_op.last);
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= RESET_ROWS[6:0];
      cols_in_use  <= RESET_COLS;
      wrap_enable  <= 1'b1;
      newline_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS:    rows_in_use  <= cfg_data[6:0];
        REG_COLS:    cols_in_use  <= cfg_data;
        REG_WRAP:    wrap_enable  <= cfg_data[0];
        REG_NEWLINE: newline_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      seq        <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        cur_valid <= 1'b1;
        seq       <= '0;
      end else if (advance) begin
        cur_valid <= !step_op.last;
        seq       <= seq_next;
      end
      // Every issued operation stores the cursor, which also keeps the
      // clamped position after the screen has shrunk.
      if (advance) begin
        cursor_row <= row_next;
        cursor_col <= col_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_byte <= byte_in;
    end
    if (advance) begin
      out_op <= step_op;
    end
  end

  assign op_kind = out_op.kind;
  assign row     = out_op.row;
  assign col     = out_op.col;
  assign glyph   = out_op.glyph;
  assign last    = out_op.last;

  // An escape handoff is always the only operation of its byte.
  `TTCE_ASSERT_IMP(a_escape_last, out_valid && out_op.kind == OP_ESCAPE, out_op.last)
  // A scroll is always followed by another operation of the same byte.
  `TTCE_ASSERT_IMP(a_scroll_not_last, out_valid && out_op.kind == OP_SCROLL, !out_op.last)
  // The sequencer never runs past the caret form of a control byte.
  `TTCE_ASSERT_IMP(a_phase_range, cur_valid, seq.phase <= CTRL_CELLS)
  // After the final operation the next byte starts from its first operation.
  `TTCE_ASSERT_NXT(a_seq_restart, advance && step_op.last, seq == '0)

endmodule
